[design/arcu_pkg.sv]
// ----------------------------------------------------------------------------
// arcu_pkg
// Types, operation codes and byte-level functions for the AES round and
// carry-less multiply unit.
// ----------------------------------------------------------------------------
package arcu_pkg;

    typedef enum logic [2:0] {
        OP_IMC      = 3'd0,
        OP_ENC      = 3'd1,
        OP_ENCLAST  = 3'd2,
        OP_DEC      = 3'd3,
        OP_DECLAST  = 3'd4,
        OP_CLMUL    = 3'd5,
        OP_KEYGEN   = 3'd6,
        OP_UNIMPL   = 3'd7
    } arcu_op_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
        logic [63:0] source_low;
        logic [63:0] source_high;
        logic [7:0]  immediate;
    } arcu_req_t;

    typedef struct packed {
        logic [63:0] result_low;
        logic [63:0] result_high;
        logic        status;
    } arcu_rsp_t;

    // Carried alongside the data between stages.
    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  immediate;
        logic        valid;
    } arcu_ctl_t;

    localparam logic [7:0] AES_POLY = 8'h1B;

    localparam logic [7:0] SBOX_FWD [256] = '{
 8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
 8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
 8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
 8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
 8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
 8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
 8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
 8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
 8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
 8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
 8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
 8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
 8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
 8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
 8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
 8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] SBOX_INV [256] = '{
 8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
 8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
 8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
 8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
 8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
 8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
 8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
 8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
 8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
 8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
 8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
 8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
 8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
 8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
 8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
    endfunction

    // Forward MixColumns on one 32-bit column (byte 0 in bits 7:0).
    function automatic logic [31:0] mix_fwd(input logic [31:0] col);
        logic [7:0] b [4];
        logic [7:0] d [4];
        logic [31:0] res;
        for (int j = 0; j < 4; j++)
        begin
            b[j] = col[8*j +: 8];
            d[j] = xtime(b[j]);
        end
        for (int r = 0; r < 4; r++)
        begin
            res[8*r +: 8] = d[r] ^ d[(r+1)%4] ^ b[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
        end
        return res;
    endfunction

    // Inverse MixColumns on one column, coefficients 0E 0B 0D 09.
    function automatic logic [31:0] mix_inv(input logic [31:0] col);
        logic [7:0] b2 [4];
        logic [7:0] b4 [4];
        logic [7:0] b8 [4];
        logic [7:0] b  [4];
        logic [31:0] res;
        for (int j = 0; j < 4; j++)
        begin
            b[j]  = col[8*j +: 8];
            b2[j] = xtime(b[j]);
            b4[j] = xtime(b2[j]);
            b8[j] = xtime(b4[j]);
        end
        for (int r = 0; r < 4; r++)
        begin
            res[8*r +: 8] = (b8[r] ^ b4[r] ^ b2[r])
                          ^ (b8[(r+1)%4] ^ b2[(r+1)%4] ^ b[(r+1)%4])
                          ^ (b8[(r+2)%4] ^ b4[(r+2)%4] ^ b[(r+2)%4])
                          ^ (b8[(r+3)%4] ^ b[(r+3)%4]);
        end
        return res;
    endfunction

endpackage

[design/aes_round_and_clmul_unit.sv]
// ----------------------------------------------------------------------------
// aes_round_and_clmul_unit
// Execution unit for AES round, key assist and carry-less multiply requests.
// ----------------------------------------------------------------------------
// Takes one request per cycle and returns one response per request, in order.
// A request passes three register stages (substitution, mixing, output). The
// first stage captures it at the accepting edge, and its response is offered
// from the output register. The carry-less product of two 64-bit operands is
// split across the first two stages. When the response consumer stalls with
// a response waiting, the whole pipeline holds and ready drops for as long
// as that response stays unaccepted.
module aes_round_and_clmul_unit
    import arcu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  arcu_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output arcu_rsp_t rsp_data
);

    arcu_ctl_t    ctl1;
    arcu_ctl_t    ctl2;
    logic [127:0] state1;
    logic [127:0] key1;
    logic [127:0] clmul1;
    logic [63:0]  ma1;
    logic [63:0]  mb1;
    logic [127:0] data2;
    logic         out_valid_reg;
    arcu_rsp_t    out_data_reg;
    logic         advance;

    // The whole pipeline moves when the output slot is free or being drained.
    assign advance   = !out_valid_reg || rsp_ready;
    assign req_ready = advance;

    arcu_sub_stage u_sub (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .request       (req_data),
        .request_valid (req_valid),
        .ctl_reg       (ctl1),
        .state_reg     (state1),
        .key_reg       (key1),
        .clmul_reg     (clmul1),
        .mult_a_reg    (ma1),
        .mult_b_reg    (mb1)
    );

    arcu_mix_stage u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .ctl_in    (ctl1),
        .state_in  (state1),
        .key_in    (key1),
        .clmul_in  (clmul1),
        .mult_a_in (ma1),
        .mult_b_in (mb1),
        .ctl_reg   (ctl2),
        .data_reg  (data2)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= ctl2.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= '{result_low: data2[63:0], result_high: data2[127:64],
                              status: (ctl2.operation == OP_UNIMPL)};
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    // A stalled response holds its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Ready follows the output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request side stalled without cause");

    // An accepted request moves on through the mixing and output registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 req_ready ##1 req_ready |=> rsp_valid)
        else $error("accepted request lost in pipeline");

endmodule

[design/arcu_sub_stage.sv]
// ----------------------------------------------------------------------------
// arcu_sub_stage
// Stage 1: row shift and S-box lookups for the AES operations and key
// assist, and the first half of the carry-less multiply partial products.
// ----------------------------------------------------------------------------
module arcu_sub_stage
    import arcu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  arcu_req_t    request,
    input  logic         request_valid,
    output arcu_ctl_t    ctl_reg,
    output logic [127:0] state_reg,
    output logic [127:0] key_reg,
    output logic [127:0] clmul_reg,
    output logic [63:0]  mult_a_reg,
    output logic [63:0]  mult_b_reg
);

    logic [127:0] dest_w;
    logic [127:0] state_next;
    logic [127:0] key_w;
    logic [63:0]  a_sel;
    logic [63:0]  b_sel;
    logic [127:0] clmul_next;
    logic [31:0]  sw1;
    logic [31:0]  sw3;
    logic [7:0]   imm;
    logic         inverse;

    assign dest_w  = {request.dest_high, request.dest_low};
    assign key_w   = {request.source_high, request.source_low};
    assign imm     = request.immediate;
    assign inverse = (request.operation == OP_DEC) || (request.operation == OP_DECLAST);

    // Row shift and byte substitution, or key-assist substitution.
    always_comb
    begin
        state_next = '0;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (inverse)
                    state_next[8*(r+4*c) +: 8] = SBOX_INV[dest_w[8*(r+4*((c-r+4)%4)) +: 8]];
                else
                    state_next[8*(r+4*c) +: 8] = SBOX_FWD[dest_w[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            sw1[8*i +: 8] = SBOX_FWD[request.source_low[32+8*i +: 8]];
            sw3[8*i +: 8] = SBOX_FWD[request.source_high[32+8*i +: 8]];
        end
        if (request.operation == OP_KEYGEN)
        begin
            state_next = {{sw3[7:0], sw3[31:8]} ^ {24'h0, imm}, sw3,
                          {sw1[7:0], sw1[31:8]} ^ {24'h0, imm}, sw1};
        end
        else if (request.operation == OP_UNIMPL)
        begin
            state_next = dest_w;
        end
    end

    // Low 32 bits of the multiplier operand handled here.
    assign a_sel = imm[0] ? request.dest_high : request.dest_low;
    assign b_sel = imm[4] ? request.source_high : request.source_low;

    always_comb
    begin
        clmul_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (a_sel[i])
                clmul_next = clmul_next ^ ({64'h0, b_sel} << i);
        end
    end

    // Stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= '{operation: request.operation, immediate: imm,
                         valid: request_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg  <= state_next;
            key_reg    <= key_w;
            clmul_reg  <= clmul_next;
            mult_a_reg <= a_sel;
            mult_b_reg <= b_sel;
        end
    end

endmodule

[design/arcu_mix_stage.sv]
// ----------------------------------------------------------------------------
// arcu_mix_stage
// Stage 2: column mixing and round key add, and the second half of the
// carry-less multiply partial products.
// ----------------------------------------------------------------------------
module arcu_mix_stage
    import arcu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  arcu_ctl_t    ctl_in,
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    input  logic [127:0] clmul_in,
    input  logic [63:0]  mult_a_in,
    input  logic [63:0]  mult_b_in,
    output arcu_ctl_t    ctl_reg,
    output logic [127:0] data_reg
);

    logic [127:0] mixed;
    logic [127:0] clmul_full;
    logic [127:0] data_next;

    // Column mixing chosen by operation.
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            case (arcu_op_t'(ctl_in.operation))
                OP_ENC:  mixed[32*c +: 32] = mix_fwd(state_in[32*c +: 32]);
                OP_DEC:  mixed[32*c +: 32] = mix_inv(state_in[32*c +: 32]);
                OP_IMC:  mixed[32*c +: 32] = mix_inv(key_in[32*c +: 32]);
                default: mixed[32*c +: 32] = state_in[32*c +: 32];
            endcase
        end
    end

    always_comb
    begin
        clmul_full = clmul_in;
        for (int i = 32; i < 64; i++)
        begin
            if (mult_a_in[i])
                clmul_full = clmul_full ^ ({64'h0, mult_b_in} << i);
        end
    end

    // Result select.
    always_comb
    begin
        case (arcu_op_t'(ctl_in.operation))
            OP_ENC, OP_ENCLAST, OP_DEC, OP_DECLAST: data_next = mixed ^ key_in;
            OP_CLMUL: data_next = clmul_full;
            default:  data_next = mixed;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (advance)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES round and carry-less multiply unit testbench
// Drives a table of directed requests and then random requests through the
// valid/ready input, computes each response with a local model of the AES
// round steps, key assist and carry-less product unless the table gives it,
// and compares them in order under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import arcu_pkg::*;

    localparam int NUM_RANDOM = 1530;
    localparam int DRAIN_CYCLES = 10;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    arcu_req_t in_data;
    logic      out_valid;
    logic      out_ready;
    arcu_rsp_t out_data;

    arcu_rsp_t pending_rsp[$];
    bit        any_error;
    bit        requests_done;

    aes_round_and_clmul_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(in_valid),
        .req_ready(in_ready),
        .req_data(in_data),
        .rsp_valid(out_valid),
        .rsp_ready(out_ready),
        .rsp_data(out_data)
    );

    // Substitution tables, kept local to the predictor.
    logic [7:0] sub_fwd [256];
    logic [7:0] sub_inv [256];

    initial
    begin
        sub_fwd = '{
 8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
 8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
 8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
 8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
 8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
 8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
 8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
 8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
 8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
 8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
 8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
 8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
 8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
 8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
 8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
 8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
        };
        // The inverse table follows from the forward one.
        for (int i = 0; i < 256; i++)
        begin
            sub_inv[sub_fwd[i]] = 8'(i);
        end
    end

    // Multiply two field elements modulo the AES polynomial.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    // Apply a circulant column matrix with first row c0..c3 to all columns.
    function automatic logic [127:0] mix_state(input logic [127:0] s,
                                               input logic [31:0] coef);
        logic [127:0] t;
        logic [7:0]   v;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int j = 0; j < 4; j++)
                begin
                    v ^= gf_mul(coef[8*((j - r) & 3) +: 8], s[8*(j + 4*c) +: 8]);
                end
                t[8*(r + 4*c) +: 8] = v;
            end
        end
        return t;
    endfunction

    // Row shift followed by byte substitution, forward or inverse.
    function automatic logic [127:0] shift_sub(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        int           src;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                src = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
                t[8*(r + 4*c) +: 8] = inv ? sub_inv[s[8*(r + 4*src) +: 8]]
                                          : sub_fwd[s[8*(r + 4*src) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_fwd[w[31:24]], sub_fwd[w[23:16]], sub_fwd[w[15:8]], sub_fwd[w[7:0]]};
    endfunction

    // Expected response of the execution unit for one request.
    function automatic arcu_rsp_t aes_clmul_result(input arcu_req_t rq);
        arcu_rsp_t    rs;
        logic [127:0] dst;
        logic [127:0] key;
        logic [127:0] acc;
        logic [63:0]  qa;
        logic [63:0]  qb;
        logic [31:0]  s1;
        logic [31:0]  s3;
        dst = {rq.dest_high, rq.dest_low};
        key = {rq.source_high, rq.source_low};
        acc = dst;
        rs.status = 1'b0;
        case (arcu_op_t'(rq.operation))
            OP_IMC:     acc = mix_state(key, 32'h090D0B0E);
            OP_ENC:     acc = mix_state(shift_sub(dst, 1'b0), 32'h01010302) ^ key;
            OP_ENCLAST: acc = shift_sub(dst, 1'b0) ^ key;
            OP_DEC:     acc = mix_state(shift_sub(dst, 1'b1), 32'h090D0B0E) ^ key;
            OP_DECLAST: acc = shift_sub(dst, 1'b1) ^ key;
            OP_CLMUL:
            begin
                qa = rq.immediate[0] ? rq.dest_high : rq.dest_low;
                qb = rq.immediate[4] ? rq.source_high : rq.source_low;
                acc = '0;
                for (int i = 0; i < 64; i++)
                begin
                    if (qa[i])
                        acc ^= {64'h0, qb} << i;
                end
            end
            OP_KEYGEN:
            begin
                s1 = sub_word(rq.source_low[63:32]);
                s3 = sub_word(rq.source_high[63:32]);
                acc = {{s3[7:0], s3[31:8]} ^ {24'h0, rq.immediate}, s3,
                       {s1[7:0], s1[31:8]} ^ {24'h0, rq.immediate}, s1};
            end
            default:    rs.status = 1'b1;
        endcase
        rs.result_low = acc[63:0];
        rs.result_high = acc[127:64];
        return rs;
    endfunction

    // Directed table; a row with a typed-in response skips the predictor.
    typedef struct {
        arcu_req_t rq;
        bit        fixed;
        arcu_rsp_t rs;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic arcu_req_t make_req(arcu_op_t op, logic [63:0] dl, logic [63:0] dh,
                                           logic [63:0] sl, logic [63:0] sh,
                                           logic [7:0] imm);
        arcu_req_t rq;
        rq.operation = op;
        rq.dest_low = dl;
        rq.dest_high = dh;
        rq.source_low = sl;
        rq.source_high = sh;
        rq.immediate = imm;
        return rq;
    endfunction

    function automatic arcu_req_t random_req();
        arcu_req_t rq;
        rq.operation = 3'($urandom_range(0, 7));
        rq.dest_low = {$urandom, $urandom};
        rq.dest_high = {$urandom, $urandom};
        rq.source_low = {$urandom, $urandom};
        rq.source_high = {$urandom, $urandom};
        rq.immediate = 8'($urandom);
        // Now and then push operands to all zeros or all ones.
        if ($urandom_range(0, 9) == 0)
            rq.dest_low = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 9) == 0)
            rq.source_high = $urandom_range(0, 1) ? '1 : '0;
        return rq;
    endfunction

    initial
    begin
        directed_row_t d;
        logic [63:0]   ones;
        ones = '1;
        d.fixed = 1'b0;
        d.rs = '0;
        for (int op = 0; op < 8; op++)
        begin
            d.rq = make_req(arcu_op_t'(op), '0, '0, '0, '0, 8'h00);
            directed_rows.push_back(d);
            d.rq = make_req(arcu_op_t'(op), ones, ones, ones, ones, 8'hFF);
            directed_rows.push_back(d);
        end
        // Carry-less product: every quadword selection, with unused imm bits set.
        for (int sel = 0; sel < 4; sel++)
        begin
            d.rq = make_req(OP_CLMUL, 64'h8000_0000_0000_0001, ones, ones,
                            64'h8000_0000_0000_0003,
                            8'hEE | {3'b0, sel[1], 3'b0, sel[0]});
            directed_rows.push_back(d);
        end
        // Unimplemented operation hands back the destination with status set.
        d.fixed = 1'b1;
        d.rq = make_req(OP_UNIMPL, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                        ones, '0, 8'h5A);
        d.rs = '{result_low: 64'h0123_4567_89AB_CDEF,
                 result_high: 64'hFEDC_BA98_7654_3210, status: 1'b1};
        directed_rows.push_back(d);
        // Zero product when both selected quadwords are zero.
        d.rq = make_req(OP_CLMUL, '0, ones, '0, ones, 8'h00);
        d.rs = '{result_low: '0, result_high: '0, status: 1'b0};
        directed_rows.push_back(d);
        // Inverse mixing of an all-zero source stays zero.
        d.rq = make_req(OP_IMC, ones, ones, '0, '0, 8'hFF);
        directed_rows.push_back(d);
    end

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Reset.
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Send one request, holding it until accepted; valid drops only for a gap.
    task automatic send_request(input arcu_req_t rq, input bit fixed, input arcu_rsp_t rs);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= rq;
        pending_rsp.push_back(fixed ? rs : aes_clmul_result(rq));
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Request side.
    initial
    begin
        arcu_rsp_t dummy;
        in_valid = 1'b0;
        in_data = '0;
        dummy = '0;
        requests_done = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].fixed, directed_rows[i].rs);
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // Hold off once until the unit has fully drained.
            if (n == NUM_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                wait (pending_rsp.size() == 0);
            end
            send_request(random_req(), 1'b0, dummy);
        end
        in_valid <= 1'b0;
        requests_done = 1'b1;
    end

    // Response side: random stalls and in-order comparison.
    initial
    begin
        arcu_rsp_t exp_rsp;
        int        stall;
        out_ready = 1'b0;
        any_error = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                any_error = 1'b1;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (out_data.result_low !== exp_rsp.result_low)
                begin
                    $error("result_low: expected %h, got %h",
                           exp_rsp.result_low, out_data.result_low);
                    any_error = 1'b1;
                end
                if (out_data.result_high !== exp_rsp.result_high)
                begin
                    $error("result_high: expected %h, got %h",
                           exp_rsp.result_high, out_data.result_high);
                    any_error = 1'b1;
                end
                if (out_data.status !== exp_rsp.status)
                begin
                    $error("status: expected %b, got %b", exp_rsp.status, out_data.status);
                    any_error = 1'b1;
                end
            end
        end
    end

    // End of run.
    initial
    begin
        wait (requests_done);
        wait (pending_rsp.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $error("%0d responses never arrived", pending_rsp.size());
            any_error = 1'b1;
        end
        if (!any_error)
            $display("** aes_round_and_clmul_unit: PASSED **");
        else
            $display("** aes_round_and_clmul_unit: FAILED **");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2000000;
        $display("** aes_round_and_clmul_unit: FAILED **");
        $finish;
    end

endmodule
